### rtl/core/cqto_pkg.sv
// shared types, constants and table builders for the wavetable oscillator
package cqto_pkg;

  localparam int unsigned TABLE_ENTRIES       = 512;
  localparam int unsigned PHASE_FRACTION_BITS = 23;
  localparam int unsigned IDX_W               = $clog2(TABLE_ENTRIES);
  localparam int unsigned PHASE_W             = IDX_W + PHASE_FRACTION_BITS;
  localparam int unsigned HALF_ENTRIES        = TABLE_ENTRIES / 2;
  localparam int unsigned SAW_SPAN            = TABLE_ENTRIES - 1;

  localparam int unsigned LEVEL_W    = 12;
  localparam int unsigned NOTE_COUNT = 92;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(500);
  localparam logic [LEVEL_W-1:0] CODE_MAX        = LEVEL_W'(4095);

  // index times full scale, and the reciprocal used for the saw divide
  localparam int unsigned SCALE_W    = IDX_W + LEVEL_W;
  localparam int unsigned SAW_SHIFT  = SCALE_W + IDX_W;
  localparam int unsigned RECIP_W    = SCALE_W + 2;
  localparam int unsigned SAW_PROD_W = SCALE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] SAW_RECIP =
    RECIP_W'(((64'd1 << SAW_SHIFT) + 64'(SAW_SPAN) - 64'd1) / 64'(SAW_SPAN));

  localparam logic [63:0] DEFAULT_CENTIHZ = 64'd44000;
  localparam logic [63:0] RATE_DIVISOR    = 64'd1025000;
  localparam logic [63:0] PI_Q30          = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_kind_t;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [IDX_W-2:0]   half_idx_t;

  typedef level_t half_rom_t [HALF_ENTRIES];
  typedef phase_t inc_rom_t [NOTE_COUNT];
  typedef logic [15:0] upper_tbl_t [NOTE_COUNT];
  typedef logic [31:0] centihz_tbl_t [NOTE_COUNT];
  typedef logic [63:0] taylor_tbl_t [7];

  // request passed from the note stage to the phase accumulator
  typedef struct packed {
    wave_kind_t kind;
    phase_t     inc;
  } step_t;

  // request passed from the phase accumulator to the wave stage
  typedef struct packed {
    wave_kind_t kind;
    idx_t       idx;
  } sample_t;

  localparam upper_tbl_t NOTE_UPPER = '{
    16'd47, 16'd113, 16'd149, 16'd186, 16'd222, 16'd257, 16'd290, 16'd326, 16'd365,
    16'd402, 16'd438, 16'd474, 16'd510, 16'd546, 16'd582, 16'd620, 16'd658, 16'd696,
    16'd732, 16'd768, 16'd805, 16'd841, 16'd880, 16'd915, 16'd950, 16'd989, 16'd1027,
    16'd1065, 16'd1101, 16'd1139, 16'd1178, 16'd1214, 16'd1249, 16'd1288,
    16'd1326, 16'd1362, 16'd1399, 16'd1436, 16'd1472, 16'd1506, 16'd1546, 16'd1588,
    16'd1624, 16'd1660, 16'd1698, 16'd1733, 16'd1768, 16'd1804,
    16'd1842, 16'd1875, 16'd1911, 16'd1952, 16'd1985, 16'd2017, 16'd2059, 16'd2102,
    16'd2140, 16'd2175, 16'd2207, 16'd2243, 16'd2280, 16'd2318,
    16'd2354, 16'd2391, 16'd2429, 16'd2465, 16'd2505, 16'd2543, 16'd2579, 16'd2617,
    16'd2653, 16'd2691, 16'd2728, 16'd2766, 16'd2804, 16'd2843,
    16'd2883, 16'd2923, 16'd2965, 16'd3005, 16'd3051, 16'd3099, 16'd3143, 16'd3191,
    16'd3243, 16'd3298, 16'd3351, 16'd3403, 16'd3462, 16'd3522,
    16'd3585, 16'd3649
  };

  localparam centihz_tbl_t NOTE_CENTIHZ = '{
    32'd147998, 32'd139691, 32'd131851, 32'd124451, 32'd117466, 32'd110873,
    32'd104650, 32'd98777, 32'd93233, 32'd88000,
    32'd83061, 32'd83061, 32'd78399, 32'd73999, 32'd69846, 32'd65926, 32'd62225,
    32'd58733, 32'd55437, 32'd52325, 32'd49388, 32'd46616,
    32'd44000, 32'd41530, 32'd39200, 32'd36999, 32'd34923, 32'd32963, 32'd31113,
    32'd29366, 32'd27718, 32'd26163, 32'd24694, 32'd23308,
    32'd22000, 32'd20765, 32'd19600, 32'd18500, 32'd17461, 32'd16481, 32'd15556,
    32'd14683, 32'd13859, 32'd13081, 32'd12347, 32'd11654,
    32'd11000, 32'd10383, 32'd9800, 32'd9250, 32'd8731, 32'd8241, 32'd7778, 32'd7342,
    32'd6930, 32'd6541, 32'd6174, 32'd5827, 32'd5500, 32'd5191,
    32'd4900, 32'd4625, 32'd4365, 32'd4120, 32'd3889, 32'd3671, 32'd3465, 32'd3270,
    32'd3087, 32'd2914, 32'd2750, 32'd2596, 32'd2450, 32'd2312,
    32'd2183, 32'd2060, 32'd1945, 32'd1835, 32'd1732, 32'd1635, 32'd1543, 32'd1457,
    32'd1375, 32'd1298, 32'd1226, 32'd1157, 32'd1092, 32'd1031,
    32'd973, 32'd919, 32'd867, 32'd819
  };

  // (2k)(2k+1) for k = 1..7
  localparam taylor_tbl_t TAYLOR_DIV = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // phase increment, rounded half up: centihz * E * 2^F / 1025000
  function automatic phase_t note_inc(input logic [63:0] centihz);
    logic [63:0] scaled;
    scaled = (centihz * 64'(TABLE_ENTRIES)) << PHASE_FRACTION_BITS;
    return PHASE_W'((scaled + RATE_DIVISOR / 2) / RATE_DIVISOR);
  endfunction

  function automatic inc_rom_t build_inc_rom();
    inc_rom_t rom;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      rom[i] = note_inc(64'(NOTE_CENTIHZ[i]));
    end
    return rom;
  endfunction

  // quadrant-folded taylor series in q30, evaluated at elaboration only
  function automatic level_t sine_code(input int unsigned idx);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic               neg;
    theta = (64'd2 * PI_Q30 * 64'(idx)) / 64'(TABLE_ENTRIES);
    neg   = 1'b0;
    if (theta >= PI_Q30) begin
      theta = theta - PI_Q30;
      neg   = 1'b1;
    end
    if (theta > HALF_PI_Q30) begin
      theta = (theta >= PI_Q30) ? 64'd0 : PI_Q30 - theta;
    end
    t2   = (theta * theta) >> 30;
    term = theta;
    s    = $signed(theta);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * t2) >> 30) / TAYLOR_DIV[k-1];
      if (k[0]) begin
        s = s - $signed(term);
      end else begin
        s = s + $signed(term);
      end
    end
    if (s > ONE_Q30) s = ONE_Q30;
    if (s < 0) s = 64'sd0;
    if (neg) s = -s;
    return LEVEL_W'(((ONE_Q30 + s) * 64'sd4095) >>> 31);
  endfunction

  // positive lobe only, the negative lobe is derived from it
  function automatic half_rom_t build_sine_rom();
    half_rom_t rom;
    for (int i = 0; i < HALF_ENTRIES; i++) begin
      rom[i] = sine_code(i);
    end
    return rom;
  endfunction

endpackage

### rtl/core/cqto_if.sv
// valid/ready channel interfaces for tick input, sample output and threshold writes
interface cqto_in_if;
  import cqto_pkg::*;
  logic   valid;
  logic   ready;
  level_t pot_level;
  level_t cv_level;
  level_t mode_switch_level;
  modport source (output valid, output pot_level, output cv_level,
                  output mode_switch_level, input ready);
  modport sink (input valid, input pot_level, input cv_level,
                input mode_switch_level, output ready);
endinterface

interface cqto_out_if;
  import cqto_pkg::*;
  logic       valid;
  logic       ready;
  level_t     dac_code;
  logic [1:0] wave_kind;
  modport source (output valid, output dac_code, output wave_kind, input ready);
  modport sink (input valid, input dac_code, input wave_kind, output ready);
endinterface

interface cqto_cfg_if;
  import cqto_pkg::*;
  logic   valid;
  logic   ready;
  level_t osc_switch_threshold;
  modport source (output valid, output osc_switch_threshold, input ready);
  modport sink (input valid, input osc_switch_threshold, output ready);
endinterface

### rtl/core/cqto_note_stage.sv
// input stage: threshold register, run gate, waveform pick and cv-to-increment lookup
module cqto_note_stage (
  input  logic           clk,
  input  logic           rst_n,
  cqto_in_if.sink        in_chan,
  cqto_cfg_if.sink       cfg_chan,
  output logic           step_valid,
  input  logic           step_ready,
  output cqto_pkg::step_t step
);
  import cqto_pkg::*;

  localparam inc_rom_t INC_ROM     = build_inc_rom();
  localparam phase_t   DEFAULT_INC = note_inc(DEFAULT_CENTIHZ);

  level_t thresh_r;
  logic   valid_r;
  step_t  step_r;
  phase_t inc_sel;
  logic   run;
  logic   take;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESHOLD_RESET;
    end else if (cfg_chan.valid) begin
      thresh_r <= cfg_chan.osc_switch_threshold;
    end
  end

  // first range whose upper bound lies above the cv reading
  always_comb begin
    inc_sel = DEFAULT_INC;
    for (int i = NOTE_COUNT - 1; i >= 0; i--) begin
      if (16'(in_chan.cv_level) < NOTE_UPPER[i]) inc_sel = INC_ROM[i];
    end
  end

  assign run           = in_chan.mode_switch_level > thresh_r;
  assign in_chan.ready = !valid_r || step_ready;
  assign take          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid && run;
    end
  end

  always_ff @(posedge clk) begin
    if (take && run) begin
      step_r.kind <= wave_kind_t'(in_chan.pot_level[LEVEL_W-1 -: 2]);
      step_r.inc  <= inc_sel;
    end
  end

  assign step_valid = valid_r;
  assign step       = step_r;

endmodule

### rtl/core/cqto_phase_acc.sv
// phase accumulator with waveform-change clear and single wrap
module cqto_phase_acc (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_valid,
  output logic             step_ready,
  input  cqto_pkg::step_t  step,
  output logic             sample_valid,
  input  logic             sample_ready,
  output cqto_pkg::sample_t sample
);
  import cqto_pkg::*;

  localparam logic [PHASE_W:0] MODULUS = (PHASE_W + 1)'(TABLE_ENTRIES) << PHASE_FRACTION_BITS;

  phase_t           phase_r;
  phase_t           phase_nxt;
  wave_kind_t       last_kind_r;
  logic             valid_r;
  sample_t          sample_r;
  phase_t           base;
  logic [PHASE_W:0] sum;
  logic             take;

  assign step_ready = !valid_r || sample_ready;
  assign take       = step_valid && step_ready;

  always_comb begin
    base = (step.kind != last_kind_r) ? '0 : phase_r;
    sum  = {1'b0, base} + {1'b0, step.inc};
    if (sum >= MODULUS) begin
      phase_nxt = PHASE_W'(sum - MODULUS);
    end else begin
      phase_nxt = PHASE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      last_kind_r <= WAVE_SINE;
      valid_r     <= 1'b0;
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        last_kind_r <= step.kind;
      end
      if (step_ready) begin
        valid_r <= step_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_r.kind <= step.kind;
      sample_r.idx  <= phase_nxt[PHASE_W-1 -: IDX_W];
    end
  end

  assign sample_valid = valid_r;
  assign sample       = sample_r;

endmodule

### rtl/core/cqto_wave_out.sv
// waveform table read into the result register
module cqto_wave_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  cqto_pkg::sample_t sample,
  cqto_out_if.source        out_chan
);
  import cqto_pkg::*;

  localparam half_rom_t SINE_ROM = build_sine_rom();

  logic                  valid_r;
  level_t                code_r;
  wave_kind_t            kind_r;
  level_t                code_nxt;
  logic                  take;
  logic                  upper_half;
  half_idx_t             half_idx;
  level_t                sine_pos;
  level_t                sine_val;
  idx_t                  tri_dist;
  logic [SCALE_W-1:0]    tri_prod;
  logic [SCALE_W-1:0]    saw_prod;
  logic [SAW_PROD_W-1:0] saw_full;

  assign sample_ready = !valid_r || out_chan.ready;
  assign take         = sample_valid && sample_ready;

  assign upper_half = sample.idx[IDX_W-1];
  assign half_idx   = sample.idx[IDX_W-2:0];
  assign sine_pos   = SINE_ROM[half_idx];

  // negative lobe mirrors the positive one, one code lower except at the peak
  assign sine_val = !upper_half ? sine_pos :
                    (sine_pos == CODE_MAX) ? '0 : (CODE_MAX - sine_pos) - level_t'(1);

  // distance back to the table end on the falling half
  assign tri_dist = upper_half ? (IDX_W'(TABLE_ENTRIES) - sample.idx) : sample.idx;
  assign tri_prod = (SCALE_W'(tri_dist) << LEVEL_W) - SCALE_W'(tri_dist);
  assign saw_prod = (SCALE_W'(sample.idx) << LEVEL_W) - SCALE_W'(sample.idx);
  assign saw_full = SAW_PROD_W'(saw_prod) * SAW_PROD_W'(SAW_RECIP);

  always_comb begin
    case (sample.kind)
      WAVE_SINE:   code_nxt = sine_val;
      WAVE_TRI:    code_nxt = LEVEL_W'(tri_prod >> (IDX_W - 1));
      WAVE_SAW:    code_nxt = LEVEL_W'(saw_full >> SAW_SHIFT);
      WAVE_SQUARE: code_nxt = upper_half ? CODE_MAX : '0;
      default:     code_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sample_ready) begin
      valid_r <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_r <= code_nxt;
      kind_r <= sample.kind;
    end
  end

  assign out_chan.valid     = valid_r;
  assign out_chan.dac_code  = code_r;
  assign out_chan.wave_kind = 2'(kind_r);

endmodule

### rtl/core/cv_quantized_table_oscillator.sv
// top level of the cv-driven wavetable oscillator
// Takes one sample tick per clock while results are drained and returns one
// 12-bit dac code per tick whose switch reading is above the threshold; ticks at
// or below it give no sample and leave the phase untouched. A taken tick passes
// three registers: after the note lookup, after the phase accumulator and after
// the waveform table read. The phase accumulator closes its loop in its phase
// register, so ticks are taken back to back as long as results are drained; a
// stalled result holds the pipeline without dropping anything. The threshold is
// written through the cfg channel, which is always ready, and resets to 500.
module cv_quantized_table_oscillator (
  input  logic       clk,
  input  logic       rst_n,
  cqto_in_if.sink    in_chan,
  cqto_out_if.source out_chan,
  cqto_cfg_if.sink   cfg_chan
);
  import cqto_pkg::*;

  logic    step_valid;
  logic    step_ready;
  step_t   step;
  logic    sample_valid;
  logic    sample_ready;
  sample_t sample;

  cqto_note_stage u_note (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step       (step)
  );

  cqto_phase_acc u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_valid   (step_valid),
    .step_ready   (step_ready),
    .step         (step),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample)
  );

  cqto_wave_out u_wave (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .out_chan     (out_chan)
  );

endmodule

### rtl/core/cqto_checker.sv
// port-level checks for the oscillator, bound to the top level
module cqto_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] dac_code,
  input logic [1:0]  wave_kind
);
  import cqto_pkg::*;

  // a stalled sample keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dac_code) && $stable(wave_kind))
    else $error("stalled sample changed");

  // square wave only swings between the rails
  a_square_rails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wave_kind == 2'(WAVE_SQUARE) |-> dac_code == '0 || dac_code == CODE_MAX)
    else $error("square sample off the rails");

  // no sample right after reset
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("sample valid after reset");

  // an empty result stage leaves the input ready afterwards unless a tick was offered
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> in_ready || $past(in_valid))
    else $error("input stalled with empty result stage");

endmodule

bind cv_quantized_table_oscillator cqto_checker u_cqto_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .dac_code  (out_chan.dac_code),
  .wave_kind (out_chan.wave_kind)
);

### verif/cv_quantized_table_oscillator_test.sv
// self-checking testbench for the cv-driven wavetable oscillator
import cqto_pkg::*;

localparam logic [11:0] CV_EDGE [92] = '{
  12'd47, 12'd113, 12'd149, 12'd186, 12'd222, 12'd257, 12'd290, 12'd326, 12'd365,
  12'd402, 12'd438, 12'd474, 12'd510, 12'd546, 12'd582, 12'd620, 12'd658, 12'd696,
  12'd732, 12'd768, 12'd805, 12'd841, 12'd880, 12'd915, 12'd950, 12'd989, 12'd1027,
  12'd1065, 12'd1101, 12'd1139, 12'd1178, 12'd1214, 12'd1249, 12'd1288,
  12'd1326, 12'd1362, 12'd1399, 12'd1436, 12'd1472, 12'd1506, 12'd1546, 12'd1588,
  12'd1624, 12'd1660, 12'd1698, 12'd1733, 12'd1768, 12'd1804,
  12'd1842, 12'd1875, 12'd1911, 12'd1952, 12'd1985, 12'd2017, 12'd2059, 12'd2102,
  12'd2140, 12'd2175, 12'd2207, 12'd2243, 12'd2280, 12'd2318,
  12'd2354, 12'd2391, 12'd2429, 12'd2465, 12'd2505, 12'd2543, 12'd2579, 12'd2617,
  12'd2653, 12'd2691, 12'd2728, 12'd2766, 12'd2804, 12'd2843,
  12'd2883, 12'd2923, 12'd2965, 12'd3005, 12'd3051, 12'd3099, 12'd3143, 12'd3191,
  12'd3243, 12'd3298, 12'd3351, 12'd3403, 12'd3462, 12'd3522,
  12'd3585, 12'd3649
};

localparam logic [31:0] CV_CENTIHZ [92] = '{
  32'd147998, 32'd139691, 32'd131851, 32'd124451, 32'd117466, 32'd110873,
  32'd104650, 32'd98777, 32'd93233, 32'd88000,
  32'd83061, 32'd83061, 32'd78399, 32'd73999, 32'd69846, 32'd65926, 32'd62225,
  32'd58733, 32'd55437, 32'd52325, 32'd49388, 32'd46616,
  32'd44000, 32'd41530, 32'd39200, 32'd36999, 32'd34923, 32'd32963, 32'd31113,
  32'd29366, 32'd27718, 32'd26163, 32'd24694, 32'd23308,
  32'd22000, 32'd20765, 32'd19600, 32'd18500, 32'd17461, 32'd16481, 32'd15556,
  32'd14683, 32'd13859, 32'd13081, 32'd12347, 32'd11654,
  32'd11000, 32'd10383, 32'd9800, 32'd9250, 32'd8731, 32'd8241, 32'd7778, 32'd7342,
  32'd6930, 32'd6541, 32'd6174, 32'd5827, 32'd5500, 32'd5191,
  32'd4900, 32'd4625, 32'd4365, 32'd4120, 32'd3889, 32'd3671, 32'd3465, 32'd3270,
  32'd3087, 32'd2914, 32'd2750, 32'd2596, 32'd2450, 32'd2312,
  32'd2183, 32'd2060, 32'd1945, 32'd1835, 32'd1732, 32'd1635, 32'd1543, 32'd1457,
  32'd1375, 32'd1298, 32'd1226, 32'd1157, 32'd1092, 32'd1031,
  32'd973, 32'd919, 32'd867, 32'd819
};

localparam logic [63:0] ANGLE_PI      = 64'd3373259426;
localparam logic [63:0] ANGLE_HALF_PI = 64'd1686629713;
localparam longint      UNIT_Q30      = 64'sd1073741824;
localparam logic [63:0] WRAP_SPAN     = 64'd1 << 32;
localparam logic [63:0] FALLBACK_CHZ  = 64'd44000;
localparam logic [63:0] RATE_DIV      = 64'd1025000;

typedef struct {
  level_t     dac;
  wave_kind_t kind;
} dac_sample_t;

class dac_sample_predictor;
  level_t      threshold;
  logic [63:0] phase;
  wave_kind_t  last_kind;
  dac_sample_t expected_samples[$];
  int          errors;
  int          ticks;
  int          silent_ticks;
  int          checked;

  function new();
    threshold = 12'd500;
    phase     = '0;
    last_kind = WAVE_SINE;
    errors    = 0;
    ticks     = 0;
    silent_ticks = 0;
    checked   = 0;
  endfunction

  function void set_threshold(level_t v);
    threshold = v;
  endfunction

  static function logic [63:0] centihz_for(level_t cv);
    for (int i = 0; i < 92; i++) begin
      if (cv < CV_EDGE[i]) return 64'(CV_CENTIHZ[i]);
    end
    return FALLBACK_CHZ;
  endfunction

  static function level_t sine_at(int unsigned idx);
    logic [63:0] ang;
    logic [63:0] sq;
    logic [63:0] tm;
    longint      acc;
    bit          flip;
    ang  = (64'd2 * ANGLE_PI * 64'(idx)) / 64'd512;
    flip = 1'b0;
    if (ang >= ANGLE_PI) begin
      ang  = ang - ANGLE_PI;
      flip = 1'b1;
    end
    // fold into the first quadrant
    if (ang > ANGLE_HALF_PI) ang = (ang >= ANGLE_PI) ? 64'd0 : ANGLE_PI - ang;
    sq  = (ang * ang) >> 30;
    tm  = ang;
    acc = longint'(ang);
    for (int k = 1; k <= 7; k++) begin
      tm = ((tm * sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(tm);
      else acc = acc + longint'(tm);
    end
    if (acc > UNIT_Q30) acc = UNIT_Q30;
    if (acc < 0) acc = 0;
    if (flip) acc = -acc;
    return 12'(((UNIT_Q30 + acc) * 64'sd4095) >>> 31);
  endfunction

  static function level_t wave_at(wave_kind_t kind, int unsigned idx);
    int unsigned v;
    case (kind)
      WAVE_SINE: return sine_at(idx);
      WAVE_TRI: begin
        v = (idx < 256) ? (idx * 4095) / 256 : ((512 - idx) * 4095) / 256;
        return (v > 4095) ? 12'd4095 : 12'(v);
      end
      WAVE_SAW: return 12'((idx * 4095) / 511);
      default:  return (idx < 256) ? 12'd0 : 12'd4095;
    endcase
  endfunction

  function void note_tick(level_t pot, level_t cv, level_t sw);
    wave_kind_t  kind;
    logic [63:0] step;
    dac_sample_t s;
    ticks++;
    if (sw <= threshold) begin
      silent_ticks++;
      return;
    end
    kind = wave_kind_t'(pot[11:10]);
    if (kind != last_kind) begin
      last_kind = kind;
      phase     = '0;
    end
    step  = (((centihz_for(cv) * 64'd512) << 23) + RATE_DIV / 2) / RATE_DIV;
    phase = phase + step;
    if (phase >= WRAP_SPAN) phase = phase - WRAP_SPAN;
    s.kind = kind;
    s.dac  = wave_at(kind, int'(phase >> 23));
    expected_samples.push_back(s);
  endfunction

  function void check_sample(level_t dac, logic [1:0] kind);
    dac_sample_t s;
    if (expected_samples.size() == 0) begin
      $display("%0t: unexpected sample, expected none, actual dac_code %0d wave_kind %0d",
               $time, dac, kind);
      errors++;
      return;
    end
    s = expected_samples.pop_front();
    checked++;
    if (dac !== s.dac) begin
      $display("%0t: dac_code mismatch, expected %0d, actual %0d", $time, s.dac, dac);
      errors++;
    end
    if (kind !== s.kind) begin
      $display("%0t: wave_kind mismatch, expected %0d, actual %0d", $time, s.kind, kind);
      errors++;
    end
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module cv_quantized_table_oscillator_test;

  logic clk = 1'b0;
  logic rst_n;

  cqto_in_if  in_chan();
  cqto_out_if out_chan();
  cqto_cfg_if cfg_chan();

  cv_quantized_table_oscillator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  dac_sample_predictor sample_pred = new();

  int         tx_idle_pct;
  int         rx_idle_pct;
  int         tx_quiet;
  int         rx_quiet;
  level_t     cur_threshold;
  wave_kind_t held_kind;
  int         settings_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the oscillator");
    $display("DONE: errors detected");
    $finish;
  end

  // accepted requests on every channel feed the predictor
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        sample_pred.set_threshold(cfg_chan.osc_switch_threshold);
      end
      if (in_chan.valid && in_chan.ready) begin
        sample_pred.note_tick(in_chan.pot_level, in_chan.cv_level,
                              in_chan.mode_switch_level);
      end
      if (out_chan.valid && out_chan.ready) begin
        sample_pred.check_sample(out_chan.dac_code, out_chan.wave_kind);
      end
    end
  end

  // result-side back-pressure, with occasional runs of no stalls
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_quiet > 0) begin
        rx_quiet--;
        out_chan.ready <= 1'b1;
      end else if ($urandom_range(199) == 0) begin
        rx_quiet = $urandom_range(60, 20);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_tick(input level_t pot, input level_t cv, input level_t sw);
    int gap;
    gap = 0;
    in_chan.valid             <= 1'b1;
    in_chan.pot_level         <= pot;
    in_chan.cv_level          <= cv;
    in_chan.mode_switch_level <= sw;
    do @(posedge clk); while (!in_chan.ready);
    if (tx_quiet > 0) begin
      tx_quiet--;
    end else begin
      if ($urandom_range(149) == 0) tx_quiet = $urandom_range(60, 20);
      while (gap < 30 && $urandom_range(99) < tx_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_threshold(input level_t v);
    in_chan.valid <= 1'b0;
    // ticks at or below threshold leave nothing to wait on, so let the pipe drain first
    repeat (4) @(posedge clk);
    while (sample_pred.pending() > 0) @(posedge clk);
    cfg_chan.valid                <= 1'b1;
    cfg_chan.osc_switch_threshold <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    cur_threshold = v;
    settings_seen++;
  endtask

  // mostly running ticks that hold one waveform, so the phase gets to wrap
  task automatic send_random_tick();
    level_t pot;
    level_t cv;
    level_t sw;
    int     r;
    if ($urandom_range(9) == 0) held_kind = wave_kind_t'($urandom_range(3));
    pot = {held_kind, 10'($urandom)};
    r = $urandom_range(99);
    if (r < 15) cv = 12'($urandom_range(4095, 3649));
    else if (r < 30) cv = CV_EDGE[$urandom_range(91)] - 12'($urandom_range(1));
    else cv = 12'($urandom_range(4095));
    if ($urandom_range(99) < 85 && cur_threshold != 12'd4095) begin
      sw = 12'($urandom_range(4095, int'(cur_threshold) + 1));
    end else begin
      sw = 12'($urandom_range(int'(cur_threshold)));
    end
    send_tick(pot, cv, sw);
  endtask

  level_t next_setting [6];

  initial begin
    rst_n                         <= 1'b0;
    in_chan.valid                 <= 1'b0;
    in_chan.pot_level             <= '0;
    in_chan.cv_level              <= '0;
    in_chan.mode_switch_level     <= '0;
    cfg_chan.valid                <= 1'b0;
    cfg_chan.osc_switch_threshold <= '0;
    tx_idle_pct   = 13;
    rx_idle_pct   = 76;
    tx_quiet      = 0;
    rx_quiet      = 0;
    cur_threshold = 12'd500;
    held_kind     = WAVE_SINE;
    settings_seen = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: threshold edge, waveform changes, note range ends, wraps
    send_tick(12'd0, 12'd0, 12'd500);
    send_tick(12'd4095, 12'd4095, 12'd0);
    send_tick(12'd0, 12'd0, 12'd501);
    repeat (6) send_tick(12'd0, 12'd0, 12'd4095);
    send_tick(12'd1023, 12'd46, 12'd4095);
    send_tick(12'd1024, 12'd47, 12'd4095);
    send_tick(12'd2047, 12'd3648, 12'd4095);
    send_tick(12'd2048, 12'd3649, 12'd4095);
    send_tick(12'd3071, 12'd4095, 12'd4095);
    send_tick(12'd3072, 12'd2000, 12'd4095);
    repeat (4) send_tick(12'd4095, 12'd0, 12'd2730);
    send_tick(12'd1365, 12'd1365, 12'd499);
    send_tick(12'd0, 12'd4095, 12'd1365);
    send_tick(12'd2730, 12'd2730, 12'd4095);

    next_setting = '{12'd500, 12'd0, 12'd4095, 12'd1, 12'd2048, 12'($urandom)};
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tx_idle_pct = 76;
        rx_idle_pct = 13;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p > 0) write_threshold(next_setting[p]);
      repeat (333) send_random_tick();
    end
    in_chan.valid <= 1'b0;

    @(posedge clk);
    while (sample_pred.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d ticks sent under %0d threshold settings and three idling patterns",
             sample_pred.ticks, settings_seen);
    $display("%0d samples compared, %0d ticks held silent by the switch",
             sample_pred.checked, sample_pred.silent_ticks);
    if (sample_pred.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/cqto_pkg.sv
rtl/core/cqto_if.sv
rtl/core/cqto_note_stage.sv
rtl/core/cqto_phase_acc.sv
rtl/core/cqto_wave_out.sv
rtl/core/cv_quantized_table_oscillator.sv
rtl/core/cqto_checker.sv
verif/cv_quantized_table_oscillator_test.sv
